// File: sv/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned StatWidth  = 2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;
endpackage
`default_nettype wire

// File: sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result with a Euclidean GCD built on one shared restoring divider.
// ----------------------------------------------------------------------------
// Result timing grows with k, the number of Euclid steps (up to about 92 at
//   W=32); add and subtract pass through ST_MUL3 and ST_SUM before the GCD,
//   while multiply and divide go from ST_MUL2 straight to it.
// Zero denominator exits in ST_IDLE, zero product in ST_MUL2, zero sum in ST_SUM.
// Throughput: one transaction at a time; ready returns in the cycle after the
//   result transaction, so the Euclid loop sets the rate.
// Reset: rst_ni clears the sequencer and the output valid; no memories.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::ValueWidth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: kind, a_num, a_den, b_num, b_den (lowest first), zero padded
  input  wire logic [((2+4*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // tdata: res_num, res_den, status (lowest first), zero padded
  output logic [((2*VALUE_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
  import rau_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned DW  = 2 * W + 1;
  localparam int unsigned CW  = $clog2(DW + 1);
  localparam int unsigned OBW = ((2 * W + 1 + 7) / 8) * 8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_MUL3 = 4'd3;
  localparam logic [3:0] ST_SUM  = 4'd4;
  localparam logic [3:0] ST_GCD  = 4'd5;
  localparam logic [3:0] ST_DIVN = 4'd6;
  localparam logic [3:0] ST_DIVD = 4'd7;
  localparam logic [3:0] ST_CHK  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [1:0]    kind_q;
  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic          sa_q, sb_q, rneg_q;
  logic [DW-1:0] t1_q, t2_q, n_q, d_q;
  logic [DW-1:0] x_q, y_q, g_q;
  // shared divider: dividend shifted into remainder, quotient into dvd
  logic [DW-1:0] dvd_q, rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          ovalid_q;
  logic [W-1:0]  onum_q;
  logic [W-2:0]  oden_q;
  logic [1:0]    ostat_q;

  // split fields
  logic [1:0]   in_kind;
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_kind = s_axis_tdata[1:0];
  assign in_an   = s_axis_tdata[2 +: W];
  assign in_ad   = s_axis_tdata[2 + W +: W];
  assign in_bn   = s_axis_tdata[2 + 2 * W +: W];
  assign in_bd   = s_axis_tdata[2 + 3 * W +: W];

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // shared multiplier operands
  logic [W-1:0]  mop_a, mop_b;
  logic [2*W-1:0] mprod;
  always_comb begin
    mop_a = an_q;
    mop_b = bd_q;
    case (state_q)
      ST_MUL1: begin
        mop_a = an_q;
        mop_b = (kind_q == KIND_MUL) ? bn_q : bd_q;
      end
      ST_MUL2: begin
        mop_a = ad_q;
        mop_b = (kind_q == KIND_DIV) ? bn_q : bd_q;
      end
      ST_MUL3: begin
        mop_a = bn_q;
        mop_b = ad_q;
      end
      default: begin
        mop_a = an_q;
        mop_b = bd_q;
      end
    endcase
  end
  assign mprod = mop_a * mop_b;

  // shared restoring divider step
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          q_bit;
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_bit   = ~rem_sub[DW];

  logic [DW-1:0] rem_nx, quo_nx;
  assign rem_nx = q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  assign quo_nx = {dvd_q[DW-2:0], q_bit};

  logic [DW-1:0] top_pos, top_neg;
  assign top_pos = DW'((64'd1 << (W - 1)) - 64'd1);
  assign top_neg = DW'(64'd1 << (W - 1));

  // signed sum of the cross products as a magnitude
  logic [DW-1:0] sum_mag;
  always_comb begin
    if (sa_q == sb_q) begin
      sum_mag = t1_q + t2_q;
    end else if (t1_q >= t2_q) begin
      sum_mag = t1_q - t2_q;
    end else begin
      sum_mag = t2_q - t1_q;
    end
  end

  logic in_take, in_zden, is_prod, prod_zero, sum_zero, res_done;
  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign in_zden   = (in_ad == '0) || (in_bd == '0) || (in_kind == KIND_DIV && in_bn == '0);
  assign is_prod   = (kind_q == KIND_MUL) || (kind_q == KIND_DIV);
  assign prod_zero = (state_q == ST_MUL2) && is_prod && (n_q == '0);
  assign sum_zero  = (state_q == ST_SUM) && (sum_mag == '0);
  assign res_done  = (state_q == ST_IDLE && in_take && in_zden) || prod_zero || sum_zero ||
                     (state_q == ST_OUT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_take && !in_zden) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: begin
        if (is_prod) begin
          state_d = prod_zero ? ST_IDLE : ST_GCD;
        end else begin
          state_d = ST_MUL3;
        end
      end
      ST_MUL3: state_d = ST_SUM;
      ST_SUM:  state_d = sum_zero ? ST_IDLE : ST_GCD;
      ST_GCD:  if (!busy_q && y_q == '0) state_d = ST_DIVN;
      ST_DIVN: if (cnt_q == '0) state_d = ST_DIVD;
      ST_DIVD: if (cnt_q == '0) state_d = ST_CHK;
      ST_CHK:  state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (res_done) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            kind_q <= in_kind;
            an_q   <= mag(in_an);
            ad_q   <= mag(in_ad);
            bn_q   <= mag(in_bn);
            bd_q   <= mag(in_bd);
            sa_q   <= in_an[W-1] ^ in_ad[W-1];
            sb_q   <= (in_bn[W-1] ^ in_bd[W-1]) ^ (in_kind == KIND_SUB);
            if (in_zden) begin
              onum_q  <= '0;
              oden_q  <= '0;
              ostat_q <= STAT_ZDEN;
            end
          end
        end
        ST_MUL1: begin
          t1_q   <= DW'(mprod);
          n_q    <= DW'(mprod);
          rneg_q <= sa_q ^ sb_q;
        end
        ST_MUL2: begin
          d_q    <= DW'(mprod);
          x_q    <= n_q;
          y_q    <= DW'(mprod);
          busy_q <= 1'b0;
          if (prod_zero) begin
            onum_q  <= '0;
            oden_q  <= (W-1)'(1);
            ostat_q <= STAT_OK;
          end
        end
        ST_MUL3: t2_q <= DW'(mprod);
        ST_SUM: begin
          n_q    <= sum_mag;
          x_q    <= sum_mag;
          y_q    <= d_q;
          busy_q <= 1'b0;
          if (sa_q == sb_q || t1_q >= t2_q) begin
            rneg_q <= sa_q;
          end else begin
            rneg_q <= sb_q;
          end
          if (sum_zero) begin
            onum_q  <= '0;
            oden_q  <= (W-1)'(1);
            ostat_q <= STAT_OK;
          end
        end
        ST_GCD: begin
          // one remainder x % y per pass over the shared divider
          if (!busy_q) begin
            if (y_q == '0) begin
              g_q   <= x_q;
              dvd_q <= n_q;
              dvs_q <= x_q;
              rem_q <= '0;
              cnt_q <= CW'(DW);
            end else begin
              dvd_q  <= x_q;
              dvs_q  <= y_q;
              rem_q  <= '0;
              cnt_q  <= CW'(DW);
              busy_q <= 1'b1;
            end
          end else if (cnt_q != '0) begin
            rem_q <= rem_nx;
            dvd_q <= quo_nx;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            x_q    <= y_q;
            y_q    <= rem_q;
            busy_q <= 1'b0;
          end
        end
        ST_DIVN: begin
          if (cnt_q != '0) begin
            rem_q <= rem_nx;
            dvd_q <= quo_nx;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            n_q   <= dvd_q;
            dvd_q <= d_q;
            dvs_q <= g_q;
            rem_q <= '0;
            cnt_q <= CW'(DW);
          end
        end
        ST_DIVD: begin
          if (cnt_q != '0) begin
            rem_q <= rem_nx;
            dvd_q <= quo_nx;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            d_q <= dvd_q;
          end
        end
        ST_CHK: begin
          if (d_q > top_pos || (rneg_q ? n_q > top_neg : n_q > top_pos)) begin
            ostat_q <= STAT_OVF;
            onum_q  <= '0;
            oden_q  <= '0;
          end else begin
            ostat_q <= STAT_OK;
            onum_q  <= rneg_q ? W'(~n_q + 1'b1) : W'(n_q);
            oden_q  <= (W-1)'(d_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OBW'({ostat_q, oden_q, onum_q});
endmodule
`default_nettype wire

// File: sv/rau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties of the stream handshake and result coding.
// ----------------------------------------------------------------------------
module rau_assertions #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::ValueWidth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((2*VALUE_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned W = VALUE_WIDTH;

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new transaction while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // status never takes the unused code
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*W:2*W-1] != 2'd3)
    else $error("bad status");

  // input ready is low in the cycle after an accepted item
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accept");
endmodule

bind rational_arithmetic_unit rau_assertions #(.VALUE_WIDTH(VALUE_WIDTH)) u_rau_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: tb/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both stream channels, works out the reduced fraction for every
// accepted operand transaction and compares each result transaction with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module rau_checker
  import rau_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  // tdata: kind, a_num, a_den, b_num, b_den (lowest first), zero padded
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: res_num, res_den, status (lowest first), zero padded
  input  wire logic [71:0]  m_axis_tdata,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  stat;
  } fraction_t;

  fraction_t fractions_due[$];

  // Magnitude of a 32-bit two's complement value, widened to 64 bits
  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'h0, v}) : {32'h0, v};
  endfunction

  function automatic logic [63:0] euclid(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(input logic [135:0] d);
    logic [1:0]  op;
    logic [63:0] an, ad, bn, bd, n, dn, g, t1, t2;
    logic        sa, sb, neg;
    fraction_t   f;
    op = d[1:0];
    an = magnitude(d[33:2]);
    ad = magnitude(d[65:34]);
    bn = magnitude(d[97:66]);
    bd = magnitude(d[129:98]);
    f = '0;
    if (ad == 0 || bd == 0 || (op == KIND_DIV && bn == 0)) begin
      f.stat = STAT_ZDEN;
      return f;
    end
    sa = d[33] != d[65];
    sb = d[97] != d[129];
    if (op == KIND_MUL) begin
      n = an * bn;
      dn = ad * bd;
      neg = sa != sb;
    end else if (op == KIND_DIV) begin
      n = an * bd;
      dn = ad * bn;
      neg = sa != sb;
    end else begin
      t1 = an * bd;
      t2 = bn * ad;
      if (op == KIND_SUB) sb = !sb;
      dn = ad * bd;
      if (sa == sb) begin
        n = t1 + t2;
        neg = sa;
      end else if (t1 >= t2) begin
        n = t1 - t2;
        neg = sa;
      end else begin
        n = t2 - t1;
        neg = sb;
      end
    end
    // Zero result is always 0/1
    if (n == 0) begin
      f.den = 31'd1;
      return f;
    end
    g = euclid(n, dn);
    n = n / g;
    dn = dn / g;
    if (dn > 64'h7fff_ffff || (neg ? n > 64'h8000_0000 : n > 64'h7fff_ffff)) begin
      f.stat = STAT_OVF;
      return f;
    end
    f.num = neg ? 32'(-n) : n[31:0];
    f.den = dn[30:0];
    return f;
  endfunction

  // Predict on operand transactions, compare on result transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    fraction_t want, got;
    int        bad;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      bad = 0;
      if (s_axis_tvalid && s_axis_tready) fractions_due.push_back(reduce_fraction(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tdata[64:63]};
        if (fractions_due.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", m_axis_tdata);
          bad = bad + 1;
        end else begin
          want = fractions_due.pop_front();
          if (want.num !== got.num) begin
            $error("res_num: expected %0d, actual %0d", $signed(want.num), $signed(got.num));
            bad = bad + 1;
          end
          if (want.den !== got.den) begin
            $error("res_den: expected %0d, actual %0d", want.den, got.den);
            bad = bad + 1;
          end
          if (want.stat !== got.stat) begin
            $error("status: expected %0d, actual %0d", want.stat, got.stat);
            bad = bad + 1;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

  assign pending_o = fractions_due.size();

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner operands and then random fractions of mixed size
// through all four operations, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  int           errors, pending;
  logic         calm = 1'b0;
  int           ops_sent[4];

  localparam logic [31:0] MAX_V = 32'h7fff_ffff;
  localparam logic [31:0] MIN_V = 32'h8000_0000;

  always #6 clk_i = ~clk_i;

  rational_arithmetic_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  rau_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  // Offer one operand transaction and hold until it is taken
  task automatic send_operands(input logic [1:0] op, input logic [31:0] an,
                               input logic [31:0] ad, input logic [31:0] bn,
                               input logic [31:0] bd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, bd, bn, ad, an, op};
    ops_sent[op]++;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // Mostly small values so reduction has work; some full range and extremes
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 32'($signed($urandom_range(0, 40)) - 20);
    if (sel < 7) return 32'($signed($urandom_range(0, 2000)) - 1000);
    if (sel < 9) return $urandom;
    case ($urandom_range(0, 4))
      0: return MAX_V;
      1: return MIN_V;
      2: return 32'd1;
      3: return 32'hffff_ffff;
      default: return 32'd0;
    endcase
  endfunction

  // Result side: random stall before each transaction
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
    end
  end

  initial begin
    #1_000_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [1:0] op;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero denominators, divide by zero, zero result, overflow
    send_operands(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
    send_operands(KIND_MUL, 32'd3, 32'd4, 32'd1, 32'd0);
    send_operands(KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
    send_operands(KIND_SUB, 32'd1, 32'd2, 32'd2, 32'd4);
    send_operands(KIND_MUL, 32'd0, 32'd5, 32'd7, 32'd9);
    send_operands(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_operands(KIND_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
    send_operands(KIND_MUL, 32'd6, 32'hffff_fff8, 32'd4, 32'd9);
    send_operands(KIND_DIV, 32'hffff_fffd, 32'd4, 32'hffff_fffa, 32'hfffffff8);
    send_operands(KIND_MUL, MIN_V, 32'd1, 32'hffff_ffff, 32'd1);
    send_operands(KIND_DIV, MIN_V, 32'd1, 32'hffff_ffff, 32'd1);
    send_operands(KIND_MUL, MIN_V, 32'd1, 32'd1, 32'd1);
    send_operands(KIND_ADD, MAX_V, 32'd1, MAX_V, 32'd1);
    send_operands(KIND_SUB, MIN_V, 32'd1, 32'd1, 32'd1);
    send_operands(KIND_ADD, 32'd1, MIN_V, 32'd0, 32'd1);
    send_operands(KIND_MUL, 32'd1, MAX_V, 32'd1, MAX_V);
    send_operands(KIND_DIV, MAX_V, MIN_V, MIN_V, MAX_V);
    send_operands(KIND_SUB, MAX_V, MAX_V, MIN_V, MIN_V);
    send_operands(KIND_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_operands(KIND_DIV, 32'd5, 32'hffff_ffff, 32'd5, 32'd1);

    // Hold off until every result is back
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    // Random: calm stretches alternate with idling on both sides
    for (int i = 0; i < 1600; i++) begin
      if (i % 200 == 0) calm <= (i % 400 == 200);
      op = 2'($urandom_range(0, 3));
      send_operands(op, pick_value(), pick_value(), pick_value(), pick_value());
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    wait (pending == 0);
    repeat (2500) @(posedge clk_i);
    $display("Covered %0d add, %0d sub, %0d mul, %0d div operand transactions,",
             ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3]);
    $display("with zero denominators, overflow, zero results and random back-pressure.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: rational_arithmetic_unit.f
sv/rau_pkg.sv
sv/rational_arithmetic_unit.sv
sv/rau_checker.sv
tb/rau_checker.sv
tb/tb.sv
